// ----- rtl/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Types and codes shared by the queue cells, the top level and the checker.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int ID_W    = 32;
   localparam int NAME_W  = 64;
   localparam int SCORE_W = 16;
   localparam int OCC_W   = 5;

   // Operation codes of a request.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes of a response.
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_REMOVED  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
      logic [NAME_W-1:0]  name;
   } spq_entry_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic          insert_en;
      logic          remove_en;
      spq_entry_type new_entry;
   } spq_ctrl_type;

endpackage : spq_pkg
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one record; on insert it keeps, shifts from its left neighbour or
// takes the new record, on remove it takes its right neighbour's record.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire spq_ctrl_type  ctrl,
   input  wire logic          occupied,
   input  wire logic          left_take,
   input  wire spq_entry_type left_entry,
   input  wire spq_entry_type right_entry,
   output spq_entry_type      entry,
   output logic               take
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // A cell gives way when it is empty or holds a strictly lower score.
   assign take  = !(occupied && (entry_ff.score >= ctrl.new_entry.score));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en && take) begin
         entry_in = left_take ? left_entry : ctrl.new_entry;
      end else if (ctrl.remove_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule : spq_cell
`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of records kept in score order, highest first, in a row of
// shifting cells. Equal scores leave in arrival order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  operation, record_id, name_tag,
//                                               score
//   rsp_      out        rsp_valid / rsp_ready  status, out_id, out_name,
//                                               out_score, occupancy
//
// Every request yields exactly one response, registered in the cycle after the
// request transfer. The whole row of cells compares against the new score
// and shifts in the same cycle, so a new request can be taken every cycle.
// The response register sets the rate under back-pressure: a request is
// taken whenever the response register is empty or is being emptied in the
// same cycle. Reset (synchronous, active high) empties the queue and the
// response register; the cell contents are not cleared, since only cells
// below the fill count are ever compared or returned.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic [ID_W-1:0]    req_record_id,
   input  wire logic [NAME_W-1:0]  req_name_tag,
   input  wire logic [SCORE_W-1:0] req_score,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [ID_W-1:0]         rsp_out_id,
   output logic [NAME_W-1:0]       rsp_out_name,
   output logic [SCORE_W-1:0]      rsp_out_score,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [1:0]      status_ff;
   logic [1:0]      status_in;
   spq_entry_type   data_ff;
   spq_entry_type   data_in;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   logic            xfer;
   logic            full;
   logic            empty;
   logic [CW+OCC_W-1:0] count_ext;
   spq_ctrl_type    ctrl;

   spq_entry_type   cell_entry [QUEUE_DEPTH];
   logic            cell_take  [QUEUE_DEPTH];

   // A request transfers when the response register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign xfer      = req_valid && req_ready;
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl.insert_en       = xfer && (req_operation == OP_INSERT) && !full;
      ctrl.remove_en       = xfer && (req_operation == OP_REMOVE) && !empty;
      ctrl.new_entry.score = req_score;
      ctrl.new_entry.id    = req_record_id;
      ctrl.new_entry.name  = req_name_tag;
   end

   // The row of cells. Cell 0 is the head; the left neighbour of cell 0 is
   // the new record itself, and the last cell reads back its own contents
   // on a remove, which is harmless as it then lies beyond the fill count.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          occupied;
      logic          left_take;
      spq_entry_type left_entry;
      spq_entry_type right_entry;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_take  = 1'b0;
         assign left_entry = ctrl.new_entry;
      end else begin : g_body
         assign left_take  = cell_take[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_take   (left_take),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .take        (cell_take[i])
      );
   end

   // Fill count and the response for the current transfer.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      data_in      = data_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CW'(1);
      end
      if (xfer) begin
         rsp_valid_in = 1'b1;
         data_in      = '0;
         if (req_operation == OP_INSERT) begin
            status_in = full ? ST_FULL : ST_INSERTED;
         end else if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_REMOVED;
            data_in   = cell_entry[0];
         end
      end
   end

   // Occupancy is reported in its low bits only.
   assign count_ext = {{OCC_W{1'b0}}, count_in};
   assign occ_in    = xfer ? count_ext[OCC_W-1:0] : occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      data_ff   <= data_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_id    = data_ff.id;
   assign rsp_out_name  = data_ff.name;
   assign rsp_out_score = data_ff.score;
   assign rsp_occupancy = occ_ff;

endmodule : sorted_priority_queue
`default_nettype wire

// ----- rtl/spq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
   import spq_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire logic [ID_W-1:0]    rsp_out_id,
   input wire logic [NAME_W-1:0]  rsp_out_name,
   input wire logic [SCORE_W-1:0] rsp_out_score,
   input wire logic [OCC_W-1:0]   rsp_occupancy
);

   // A stalled response holds its status and occupancy.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   // Only a removal carries record data.
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_REMOVED) |->
         (rsp_out_id == '0) && (rsp_out_name == '0) && (rsp_out_score == '0))
      else $error("record data on a response that is not a removal");

   // An empty report always comes with zero occupancy.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

   // No response is shown straight after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule : spq_checker

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_out_id    (rsp_out_id),
   .rsp_out_name  (rsp_out_name),
   .rsp_out_score (rsp_out_score),
   .rsp_occupancy (rsp_occupancy)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove requests into the queue and keeps a shadow copy of
// the sorted records. Every response is compared field by field with the
// outcome that the shadow predicts. The run starts with a few hand-picked
// requests and then sends random traffic under four patterns of idling and
// back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH     = 16;
   localparam int ITEMS_PER_PHASE = 325;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int SETTLE_CYCLES   = 4;

   // One predicted response, in the same field order as the response port.
   typedef struct packed {
      logic [1:0]         status;
      logic [ID_W-1:0]    id;
      logic [NAME_W-1:0]  name;
      logic [SCORE_W-1:0] score;
      logic [OCC_W-1:0]   occupancy;
   } queue_outcome_type;

   // Shadow of the queue contents. Each accepted request is applied to the
   // shadow at once, and the response it should produce is queued until the
   // block delivers it.
   class queue_shadow_type;
      logic [SCORE_W-1:0] rec_score[QUEUE_DEPTH];
      logic [ID_W-1:0]    rec_id[QUEUE_DEPTH];
      logic [NAME_W-1:0]  rec_name[QUEUE_DEPTH];
      int unsigned        level;
      queue_outcome_type  awaited[$];
      int unsigned        errors, inserts, removes, refusals, empties, peak;

      function void apply_request(logic op, logic [ID_W-1:0] id,
                                  logic [NAME_W-1:0] name, logic [SCORE_W-1:0] score);
         queue_outcome_type outcome;
         int                pos;
         outcome = '0;
         if (op == OP_INSERT) begin
            if (level >= QUEUE_DEPTH) begin
               outcome.status = ST_FULL;
               refusals++;
            end else begin
               // Lower scores move down one place; equal scores stay ahead.
               pos = level;
               while (pos > 0 && rec_score[pos-1] < score) begin
                  rec_score[pos] = rec_score[pos-1];
                  rec_id[pos]    = rec_id[pos-1];
                  rec_name[pos]  = rec_name[pos-1];
                  pos--;
               end
               rec_score[pos] = score;
               rec_id[pos]    = id;
               rec_name[pos]  = name;
               level++;
               outcome.status = ST_INSERTED;
               inserts++;
            end
         end else if (level == 0) begin
            outcome.status = ST_EMPTY;
            empties++;
         end else begin
            outcome.status = ST_REMOVED;
            outcome.id     = rec_id[0];
            outcome.name   = rec_name[0];
            outcome.score  = rec_score[0];
            for (pos = 0; pos + 1 < level; pos++) begin
               rec_score[pos] = rec_score[pos+1];
               rec_id[pos]    = rec_id[pos+1];
               rec_name[pos]  = rec_name[pos+1];
            end
            level--;
            removes++;
         end
         if (level > peak)
            peak = level;
         outcome.occupancy = level[OCC_W-1:0];
         awaited.push_back(outcome);
      endfunction

      function void compare_field(string field, logic [NAME_W-1:0] want,
                                  logic [NAME_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void compare_response(logic [1:0] status, logic [ID_W-1:0] id,
                                     logic [NAME_W-1:0] name, logic [SCORE_W-1:0] score,
                                     logic [OCC_W-1:0] occupancy);
         queue_outcome_type want;
         if (awaited.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
         end else begin
            want = awaited.pop_front();
            compare_field("status", NAME_W'(want.status), NAME_W'(status));
            compare_field("out_id", NAME_W'(want.id), NAME_W'(id));
            compare_field("out_name", want.name, name);
            compare_field("out_score", NAME_W'(want.score), NAME_W'(score));
            compare_field("occupancy", NAME_W'(want.occupancy), NAME_W'(occupancy));
         end
      endfunction
   endclass

   // Every input starts at a known value.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = OP_INSERT;
   logic [ID_W-1:0]    req_record_id = '0;
   logic [NAME_W-1:0]  req_name_tag = '0;
   logic [SCORE_W-1:0] req_score = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [ID_W-1:0]    rsp_out_id;
   logic [NAME_W-1:0]  rsp_out_name;
   logic [SCORE_W-1:0] rsp_out_score;
   logic [OCC_W-1:0]   rsp_occupancy;

   queue_shadow_type shadow = new();

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   // The sender's own count of stored records, used only to steer the traffic.
   int unsigned fill_guess = 0;
   int unsigned sent = 0;
   int unsigned quiet_cycles = 0;

   always #1 clock = ~clock;

   sorted_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_record_id (req_record_id),
      .req_name_tag  (req_name_tag),
      .req_score     (req_score),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_name  (rsp_out_name),
      .rsp_out_score (rsp_out_score),
      .rsp_occupancy (rsp_occupancy)
   );

   // The receiver stalls at random, at the rate that the current phase sets.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Both channels are sampled at the clock edge, before any of this edge's
   // updates land, so the values seen are the ones that made the transfer.
   // Requests are applied to the shadow first, then the response is checked;
   // the response is registered, so it never belongs to this edge's request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            shadow.apply_request(req_operation, req_record_id, req_name_tag, req_score);
         if (rsp_valid && rsp_ready)
            shadow.compare_response(rsp_status, rsp_out_id, rsp_out_name,
                                    rsp_out_score, rsp_occupancy);
      end
   end

   // The watchdog counts cycles without a transfer on either channel. A long
   // silence means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("** sorted_priority_queue: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one request after a random idle gap and holds it until the
   // transfer. Called at a clock edge and returns at the edge of the transfer,
   // so the next call or idle cycle makes the only assignment of that edge.
   task automatic issue_item(input logic op, input logic [ID_W-1:0] id,
                             input logic [NAME_W-1:0] name,
                             input logic [SCORE_W-1:0] score);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_record_id <= id;
      req_name_tag  <= name;
      req_score     <= score;
      do
         @(posedge clock);
      while (!req_ready);
      if (op == OP_INSERT && fill_guess < QUEUE_DEPTH)
         fill_guess++;
      else if (op == OP_REMOVE && fill_guess > 0)
         fill_guess--;
      sent++;
   endtask

   // Random content for one request. Scores lean towards the extremes and a
   // handful of small values, so that ties are frequent.
   task automatic issue_random(input logic op);
      logic [SCORE_W-1:0] score;
      case ($urandom_range(3))
         0:       score = SCORE_W'($urandom_range(3));
         1:       score = $urandom_range(1) ? '1 : '0;
         2:       score = SCORE_W'(16'hFFFF - $urandom_range(2));
         default: score = SCORE_W'($urandom_range(16'hFFFF));
      endcase
      issue_item(op, $urandom, {$urandom, $urandom}, score);
   endtask

   // Lowers the request valid and waits until every response has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.awaited.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned phase;
      int unsigned pick;
      int unsigned extra;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Hand-picked opening: a remove from the empty queue, the extreme field
      // values, ties at both ends of the score range, then a full drain.
      idle_pct  = 9;
      stall_pct = 9;
      issue_item(OP_REMOVE, '1, '1, '1);
      issue_item(OP_INSERT, '0, '0, '0);
      issue_item(OP_INSERT, '1, '1, '1);
      issue_item(OP_INSERT, 32'h4142_4344, 64'h0123_4567_89AB_CDEF, '1);
      issue_item(OP_INSERT, 32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, '0);
      issue_item(OP_INSERT, 32'h0000_8001, 64'h8000_0000_0000_0001, 16'h8000);
      issue_item(OP_INSERT, 32'h7FFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFE, 16'h7FFF);
      repeat (6) issue_item(OP_REMOVE, '0, '0, '0);
      issue_item(OP_REMOVE, '0, '0, '0);

      // The queue is empty again, so the pause also shows that nothing is
      // left outstanding before the random traffic starts.
      drain_responses();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               // Fill to the top, then push against the full queue.
               while (fill_guess < QUEUE_DEPTH)
                  issue_random(OP_INSERT);
               extra = $urandom_range(1, 2);
               repeat (extra) issue_random(OP_INSERT);
            end else if (pick == 1) begin
               // Empty the queue, then ask once more.
               while (fill_guess > 0)
                  issue_random(OP_REMOVE);
               issue_random(OP_REMOVE);
            end else if (fill_guess < 4) begin
               issue_random(($urandom_range(99) < 70) ? OP_INSERT : OP_REMOVE);
            end else if (fill_guess > 12) begin
               issue_random(($urandom_range(99) < 30) ? OP_INSERT : OP_REMOVE);
            end else begin
               issue_random($urandom_range(1) ? OP_REMOVE : OP_INSERT);
            end
         end
         // Hold the sender back until the block has answered everything.
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d refused as full, %0d removes, %0d on an empty queue.",
               shadow.inserts, shadow.refusals, shadow.removes, shadow.empties);
      $display("Peak occupancy %0d of %0d; %0d field mismatches or stray responses.",
               shadow.peak, QUEUE_DEPTH, shadow.errors);
      if (shadow.errors == 0)
         $display("** sorted_priority_queue: PASSED **");
      else
         $display("** sorted_priority_queue: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/testbench.sv
